[rtl/rtb_pkg.sv]
// shared types, constants and helpers for the r-tree bulk load builder
`timescale 1ns / 1ps
package rtb_pkg;

  localparam int MaxRects  = 1024;
  localparam int MaxFanout = 8;
  localparam int MaxNodes  = 2048;
  localparam int RIW  = $clog2(MaxRects);
  localparam int CNTW = RIW + 1;
  localparam int NIW  = $clog2(MaxNodes);
  localparam int FW   = 4;
  localparam int LVW  = 4;
  localparam int KEYW = 16;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_BUILD = 2'd1,
    CMD_RNODE = 2'd2,
    CMD_RSORT = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_RANGE    = 3'd3,
    ST_NOTBUILT = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_RD, S_RD_OUT, S_B_INIT,
    S_KI_RD, S_KI_CAP, S_KJ_RD, S_KJ_CMP, S_RANK_WR,
    S_LV_INIT, S_G_INIT, S_E_RD, S_E_RD2, S_E_MRG, S_N_WR, S_L_NEXT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_LOAD, OP_RD, OP_RD_OUT, OP_B_INIT,
    OP_KI_RD, OP_KI_CAP, OP_KJ_RD, OP_KJ_CMP, OP_RANK_WR,
    OP_LV_INIT, OP_G_INIT, OP_E_RD, OP_E_RD2, OP_E_MRG, OP_N_WR, OP_L_NEXT
  } dp_op_t;

  typedef struct packed {
    logic signed [15:0] xl;
    logic signed [15:0] yl;
    logic signed [15:0] xh;
    logic signed [15:0] yh;
  } box_t;

  typedef struct packed {
    logic [LVW-1:0] level;
    logic [NIW-1:0] first;
    logic [FW-1:0]  count;
  } link_t;

  typedef struct packed {
    dp_op_t op;
  } ctl_t;

  typedef struct packed {
    logic empty;
    logic j_last;
    logic i_last;
    logic k_last;
    logic grp_last;
    logic root;
    logic leaf;
  } sts_t;

  // center x truncated toward zero
  function automatic logic signed [KEYW-1:0] center_x(logic signed [15:0] a,
                                                      logic signed [15:0] b);
    logic signed [16:0] s;
    logic signed [16:0] t;
    s = 17'(a) + 17'(b);
    t = s + ((s[16] && s[0]) ? 17'sd1 : 17'sd0);
    return t[16:1];
  endfunction

endpackage

[rtl/rtb_ctrl.sv]
// sequencing state machine for load, read and build words
`timescale 1ns / 1ps
module rtb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [1:0]    in_cmd,
  input  rtb_pkg::sts_t sts,
  output logic          busy,
  output rtb_pkg::ctl_t ctl
);

  rtb_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rtb_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rtb_pkg::S_IDLE: begin
        if (start) begin
          unique case (rtb_pkg::cmd_t'(in_cmd))
            rtb_pkg::CMD_LOAD:  state_nxt = rtb_pkg::S_LOAD;
            rtb_pkg::CMD_BUILD: state_nxt = rtb_pkg::S_B_INIT;
            default:            state_nxt = rtb_pkg::S_RD;
          endcase
        end
      end
      rtb_pkg::S_LOAD:    state_nxt = rtb_pkg::S_IDLE;
      rtb_pkg::S_RD:      state_nxt = rtb_pkg::S_RD_OUT;
      rtb_pkg::S_RD_OUT:  state_nxt = rtb_pkg::S_IDLE;
      rtb_pkg::S_B_INIT:  state_nxt = sts.empty ? rtb_pkg::S_IDLE : rtb_pkg::S_KI_RD;
      rtb_pkg::S_KI_RD:   state_nxt = rtb_pkg::S_KI_CAP;
      rtb_pkg::S_KI_CAP:  state_nxt = rtb_pkg::S_KJ_RD;
      rtb_pkg::S_KJ_RD:   state_nxt = rtb_pkg::S_KJ_CMP;
      rtb_pkg::S_KJ_CMP:  state_nxt = sts.j_last ? rtb_pkg::S_RANK_WR : rtb_pkg::S_KJ_RD;
      rtb_pkg::S_RANK_WR: state_nxt = sts.i_last ? rtb_pkg::S_LV_INIT : rtb_pkg::S_KI_RD;
      rtb_pkg::S_LV_INIT: state_nxt = rtb_pkg::S_G_INIT;
      rtb_pkg::S_G_INIT:  state_nxt = rtb_pkg::S_E_RD;
      rtb_pkg::S_E_RD:    state_nxt = sts.leaf ? rtb_pkg::S_E_RD2 : rtb_pkg::S_E_MRG;
      rtb_pkg::S_E_RD2:   state_nxt = rtb_pkg::S_E_MRG;
      rtb_pkg::S_E_MRG:   state_nxt = sts.k_last ? rtb_pkg::S_N_WR : rtb_pkg::S_E_RD;
      rtb_pkg::S_N_WR:    state_nxt = sts.grp_last ? rtb_pkg::S_L_NEXT : rtb_pkg::S_G_INIT;
      rtb_pkg::S_L_NEXT:  state_nxt = sts.root ? rtb_pkg::S_IDLE : rtb_pkg::S_G_INIT;
      default:            state_nxt = rtb_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy   = (state_r != rtb_pkg::S_IDLE);
    ctl.op = rtb_pkg::OP_NONE;
    unique case (state_r)
      rtb_pkg::S_IDLE:    ctl.op = start ? rtb_pkg::OP_ACCEPT : rtb_pkg::OP_NONE;
      rtb_pkg::S_LOAD:    ctl.op = rtb_pkg::OP_LOAD;
      rtb_pkg::S_RD:      ctl.op = rtb_pkg::OP_RD;
      rtb_pkg::S_RD_OUT:  ctl.op = rtb_pkg::OP_RD_OUT;
      rtb_pkg::S_B_INIT:  ctl.op = rtb_pkg::OP_B_INIT;
      rtb_pkg::S_KI_RD:   ctl.op = rtb_pkg::OP_KI_RD;
      rtb_pkg::S_KI_CAP:  ctl.op = rtb_pkg::OP_KI_CAP;
      rtb_pkg::S_KJ_RD:   ctl.op = rtb_pkg::OP_KJ_RD;
      rtb_pkg::S_KJ_CMP:  ctl.op = rtb_pkg::OP_KJ_CMP;
      rtb_pkg::S_RANK_WR: ctl.op = rtb_pkg::OP_RANK_WR;
      rtb_pkg::S_LV_INIT: ctl.op = rtb_pkg::OP_LV_INIT;
      rtb_pkg::S_G_INIT:  ctl.op = rtb_pkg::OP_G_INIT;
      rtb_pkg::S_E_RD:    ctl.op = rtb_pkg::OP_E_RD;
      rtb_pkg::S_E_RD2:   ctl.op = rtb_pkg::OP_E_RD2;
      rtb_pkg::S_E_MRG:   ctl.op = rtb_pkg::OP_E_MRG;
      rtb_pkg::S_N_WR:    ctl.op = rtb_pkg::OP_N_WR;
      rtb_pkg::S_L_NEXT:  ctl.op = rtb_pkg::OP_L_NEXT;
      default:            ctl.op = rtb_pkg::OP_NONE;
    endcase
  end

endmodule

[rtl/rtb_dp.sv]
// datapath: stores, sort ranking, node packing and result registers
`timescale 1ns / 1ps
module rtb_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rtb_pkg::ctl_t             ctl,
  output rtb_pkg::sts_t             sts,
  input  logic [1:0]                in_cmd,
  input  logic signed [15:0]        in_x_low,
  input  logic signed [15:0]        in_y_low,
  input  logic signed [15:0]        in_x_high,
  input  logic signed [15:0]        in_y_high,
  input  logic [10:0]               in_addr,
  input  logic                      cfg_we,
  input  logic [3:0]                cfg_fanout,
  output logic                      out_valid,
  output logic [2:0]                out_status,
  output logic signed [15:0]        out_mbr_x_low,
  output logic signed [15:0]        out_mbr_y_low,
  output logic signed [15:0]        out_mbr_x_high,
  output logic signed [15:0]        out_mbr_y_high,
  output logic [3:0]                out_level,
  output logic [10:0]               out_first_child,
  output logic [3:0]                out_child_count,
  output logic [9:0]                out_rect_id,
  output logic [10:0]               out_node_count
);

  localparam int RIW  = rtb_pkg::RIW;
  localparam int CNTW = rtb_pkg::CNTW;
  localparam int NIW  = rtb_pkg::NIW;
  localparam int FW   = rtb_pkg::FW;
  localparam int LVW  = rtb_pkg::LVW;
  localparam int KEYW = rtb_pkg::KEYW;

  rtb_pkg::box_t  rect_mem  [rtb_pkg::MaxRects];
  logic [KEYW-1:0] key_mem  [rtb_pkg::MaxRects];
  logic [RIW-1:0] sort_mem  [rtb_pkg::MaxRects];
  rtb_pkg::box_t  nbox_mem  [rtb_pkg::MaxNodes];
  rtb_pkg::link_t nlink_mem [rtb_pkg::MaxNodes];

  rtb_pkg::box_t  rect_q, nbox_q;
  logic [KEYW-1:0] key_q;
  logic [RIW-1:0] sort_q;
  rtb_pkg::link_t nlink_q;

  logic [1:0]     cmd_r;
  rtb_pkg::box_t  in_box_r;
  logic [NIW-1:0] addr_r;
  logic [FW-1:0]  fanout_r;
  logic [CNTW-1:0] rcnt_r, rcnt_nxt;
  logic [NIW-1:0] nodes_r, nodes_nxt;
  logic           valid_r, valid_nxt;
  logic [RIW-1:0] i_r, i_nxt, j_r, j_nxt, rank_r, rank_nxt;
  logic signed [KEYW-1:0] keyi_r, keyi_nxt;
  logic [FW-1:0]  m_r, m_nxt;
  logic           leaf_r, leaf_nxt;
  logic [NIW-1:0] pos_r, pos_nxt, rem_r, rem_nxt, next_r, next_nxt, par_r, par_nxt;
  logic [NIW-1:0] gfirst_r, gfirst_nxt;
  logic [LVW-1:0] level_r, level_nxt;
  logic [FW-1:0]  gcnt_r, gcnt_nxt, k_r, k_nxt;
  rtb_pkg::box_t  acc_r, acc_nxt, elem;

  logic           ov_r, ov_nxt;
  logic [2:0]     ost_r, ost_nxt;
  rtb_pkg::box_t  obox_r, obox_nxt;
  rtb_pkg::link_t olink_r, olink_nxt;
  logic [9:0]     oid_r, oid_nxt;
  logic [10:0]    onc_r, onc_nxt;

  logic [RIW-1:0] key_ra, sort_ra;
  logic [NIW-1:0] nbox_ra;
  logic           full;
  logic [FW-1:0]  m_clamp;
  logic signed [KEYW-1:0] keyj;

  assign full = (rcnt_r == CNTW'(rtb_pkg::MaxRects));
  assign m_clamp = (fanout_r < FW'(2)) ? FW'(2) :
                   (fanout_r > FW'(rtb_pkg::MaxFanout)) ? FW'(rtb_pkg::MaxFanout) : fanout_r;
  assign keyj = key_q;
  assign elem = leaf_r ? rect_q : nbox_q;

  assign key_ra  = (ctl.op == rtb_pkg::OP_KI_RD) ? i_r : j_r;
  assign sort_ra = (ctl.op == rtb_pkg::OP_RD) ? addr_r[RIW-1:0] : pos_r[RIW-1:0];
  assign nbox_ra = (ctl.op == rtb_pkg::OP_RD) ? addr_r : pos_r;

  assign sts.empty    = (rcnt_r == '0);
  assign sts.j_last   = ({1'b0, j_r} == rcnt_r - CNTW'(1));
  assign sts.i_last   = ({1'b0, i_r} == rcnt_r - CNTW'(1));
  assign sts.k_last   = (k_r == gcnt_r - FW'(1));
  assign sts.grp_last = (rem_r == NIW'(gcnt_r));
  assign sts.root     = (par_r == NIW'(1));
  assign sts.leaf     = leaf_r;

  // stores
  always_ff @(posedge clk) begin
    if (ctl.op == rtb_pkg::OP_LOAD && !full) begin
      rect_mem[rcnt_r[RIW-1:0]] <= in_box_r;
      key_mem[rcnt_r[RIW-1:0]]  <= rtb_pkg::center_x(in_box_r.xl, in_box_r.xh);
    end
    if (ctl.op == rtb_pkg::OP_RANK_WR) begin
      sort_mem[rank_r] <= i_r;
    end
    if (ctl.op == rtb_pkg::OP_N_WR) begin
      nbox_mem[next_r]  <= acc_r;
      nlink_mem[next_r] <= '{level: level_r, first: gfirst_r, count: gcnt_r};
    end
    rect_q  <= rect_mem[sort_q];
    key_q   <= key_mem[key_ra];
    sort_q  <= sort_mem[sort_ra];
    nbox_q  <= nbox_mem[nbox_ra];
    nlink_q <= nlink_mem[addr_r];
  end

  always_comb begin
    rcnt_nxt = rcnt_r;  nodes_nxt = nodes_r;  valid_nxt = valid_r;
    i_nxt = i_r;  j_nxt = j_r;  rank_nxt = rank_r;  keyi_nxt = keyi_r;
    m_nxt = m_r;  leaf_nxt = leaf_r;  pos_nxt = pos_r;  rem_nxt = rem_r;
    next_nxt = next_r;  par_nxt = par_r;  gfirst_nxt = gfirst_r;
    level_nxt = level_r;  gcnt_nxt = gcnt_r;  k_nxt = k_r;  acc_nxt = acc_r;
    ov_nxt = 1'b0;  ost_nxt = ost_r;  obox_nxt = obox_r;  olink_nxt = olink_r;
    oid_nxt = oid_r;  onc_nxt = onc_r;
    case (ctl.op)
      rtb_pkg::OP_LOAD: begin
        ov_nxt = 1'b1;  obox_nxt = '0;  olink_nxt = '0;  oid_nxt = '0;
        if (full) begin
          ost_nxt = rtb_pkg::ST_FULL;
          onc_nxt = valid_r ? nodes_r : '0;
        end else begin
          ost_nxt = rtb_pkg::ST_OK;
          oid_nxt = rcnt_r[9:0];
          onc_nxt = '0;
          rcnt_nxt = rcnt_r + CNTW'(1);
          valid_nxt = 1'b0;
          nodes_nxt = '0;
        end
      end
      rtb_pkg::OP_RD_OUT: begin
        ov_nxt = 1'b1;  obox_nxt = '0;  olink_nxt = '0;  oid_nxt = '0;
        onc_nxt = valid_r ? nodes_r : '0;
        if (!valid_r) begin
          ost_nxt = rtb_pkg::ST_NOTBUILT;
        end else if (rtb_pkg::cmd_t'(cmd_r) == rtb_pkg::CMD_RNODE) begin
          if (addr_r >= nodes_r) begin
            ost_nxt = rtb_pkg::ST_RANGE;
          end else begin
            ost_nxt = rtb_pkg::ST_OK;  obox_nxt = nbox_q;  olink_nxt = nlink_q;
          end
        end else begin
          if (addr_r >= rcnt_r) begin
            ost_nxt = rtb_pkg::ST_RANGE;
          end else begin
            ost_nxt = rtb_pkg::ST_OK;  oid_nxt = sort_q;
          end
        end
      end
      rtb_pkg::OP_B_INIT: begin
        valid_nxt = 1'b0;  nodes_nxt = '0;  m_nxt = m_clamp;  i_nxt = '0;
        if (rcnt_r == '0) begin
          ov_nxt = 1'b1;  ost_nxt = rtb_pkg::ST_EMPTY;
          obox_nxt = '0;  olink_nxt = '0;  oid_nxt = '0;  onc_nxt = '0;
        end
      end
      rtb_pkg::OP_KI_CAP: begin
        keyi_nxt = key_q;  j_nxt = '0;  rank_nxt = '0;
      end
      rtb_pkg::OP_KJ_CMP: begin
        if (keyj < keyi_r || (keyj == keyi_r && j_r < i_r)) begin
          rank_nxt = rank_r + RIW'(1);
        end
        j_nxt = j_r + RIW'(1);
      end
      rtb_pkg::OP_RANK_WR: begin
        i_nxt = i_r + RIW'(1);
      end
      rtb_pkg::OP_LV_INIT: begin
        leaf_nxt = 1'b1;  pos_nxt = '0;  rem_nxt = rcnt_r;
        next_nxt = '0;  par_nxt = '0;  level_nxt = '0;
      end
      rtb_pkg::OP_G_INIT: begin
        gcnt_nxt = (rem_r < NIW'(m_r)) ? rem_r[FW-1:0] : m_r;
        gfirst_nxt = pos_r;
        k_nxt = '0;
      end
      rtb_pkg::OP_E_MRG: begin
        if (k_r == '0) begin
          acc_nxt = elem;
        end else begin
          if (elem.xl < acc_r.xl) acc_nxt.xl = elem.xl;
          if (elem.yl < acc_r.yl) acc_nxt.yl = elem.yl;
          if (elem.xh > acc_r.xh) acc_nxt.xh = elem.xh;
          if (elem.yh > acc_r.yh) acc_nxt.yh = elem.yh;
        end
        k_nxt = k_r + FW'(1);
        pos_nxt = pos_r + NIW'(1);
      end
      rtb_pkg::OP_N_WR: begin
        next_nxt = next_r + NIW'(1);
        rem_nxt = rem_r - NIW'(gcnt_r);
        par_nxt = par_r + NIW'(1);
      end
      rtb_pkg::OP_L_NEXT: begin
        if (par_r == NIW'(1)) begin
          nodes_nxt = next_r;  valid_nxt = 1'b1;
          ov_nxt = 1'b1;  ost_nxt = rtb_pkg::ST_OK;
          obox_nxt = acc_r;
          olink_nxt = '{level: level_r, first: gfirst_r, count: gcnt_r};
          oid_nxt = '0;  onc_nxt = next_r;
        end else begin
          pos_nxt = next_r - par_r;  rem_nxt = par_r;  par_nxt = '0;
          leaf_nxt = 1'b0;  level_nxt = level_r + LVW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rcnt_r   <= '0;
      nodes_r  <= '0;
      valid_r  <= 1'b0;
      fanout_r <= FW'(4);
      ov_r     <= 1'b0;
    end else begin
      rcnt_r  <= rcnt_nxt;
      nodes_r <= nodes_nxt;
      valid_r <= valid_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) fanout_r <= cfg_fanout;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == rtb_pkg::OP_ACCEPT) begin
      cmd_r    <= in_cmd;
      in_box_r <= '{xl: in_x_low, yl: in_y_low, xh: in_x_high, yh: in_y_high};
      addr_r   <= in_addr;
    end
    i_r <= i_nxt;  j_r <= j_nxt;  rank_r <= rank_nxt;  keyi_r <= keyi_nxt;
    m_r <= m_nxt;  leaf_r <= leaf_nxt;  pos_r <= pos_nxt;  rem_r <= rem_nxt;
    next_r <= next_nxt;  par_r <= par_nxt;  gfirst_r <= gfirst_nxt;
    level_r <= level_nxt;  gcnt_r <= gcnt_nxt;  k_r <= k_nxt;  acc_r <= acc_nxt;
    ost_r <= ost_nxt;  obox_r <= obox_nxt;  olink_r <= olink_nxt;
    oid_r <= oid_nxt;  onc_r <= onc_nxt;
  end

  assign out_valid       = ov_r;
  assign out_status      = ost_r;
  assign out_mbr_x_low   = obox_r.xl;
  assign out_mbr_y_low   = obox_r.yl;
  assign out_mbr_x_high  = obox_r.xh;
  assign out_mbr_y_high  = obox_r.yh;
  assign out_level       = olink_r.level;
  assign out_first_child = olink_r.first;
  assign out_child_count = olink_r.count;
  assign out_rect_id     = oid_r;
  assign out_node_count  = onc_r;

endmodule

[rtl/rtree_bulk_load_builder.sv]
// top level of the r-tree bulk load builder
`timescale 1ns / 1ps
// a word is taken when start is high and busy is low; its one result shows for a
// single cycle with out_valid and cannot be held off. build ranks every rectangle
// against all others through one key memory port, then packs the nodes level by
// level from the leaves up; the result follows the root.
module rtree_bulk_load_builder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_cmd,
  input  logic signed [15:0] in_x_low,
  input  logic signed [15:0] in_y_low,
  input  logic signed [15:0] in_x_high,
  input  logic signed [15:0] in_y_high,
  input  logic [10:0]        in_addr,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_fanout,
  output logic               out_valid,
  output logic [2:0]         out_status,
  output logic signed [15:0] out_mbr_x_low,
  output logic signed [15:0] out_mbr_y_low,
  output logic signed [15:0] out_mbr_x_high,
  output logic signed [15:0] out_mbr_y_high,
  output logic [3:0]         out_level,
  output logic [10:0]        out_first_child,
  output logic [3:0]         out_child_count,
  output logic [9:0]         out_rect_id,
  output logic [10:0]        out_node_count
);

  rtb_pkg::ctl_t ctl;
  rtb_pkg::sts_t sts;

  rtb_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .sts    (sts),
    .busy   (busy),
    .ctl    (ctl)
  );

  rtb_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .sts             (sts),
    .in_cmd          (in_cmd),
    .in_x_low        (in_x_low),
    .in_y_low        (in_y_low),
    .in_x_high       (in_x_high),
    .in_y_high       (in_y_high),
    .in_addr         (in_addr),
    .cfg_we          (cfg_we),
    .cfg_fanout      (cfg_fanout),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_mbr_x_low   (out_mbr_x_low),
    .out_mbr_y_low   (out_mbr_y_low),
    .out_mbr_x_high  (out_mbr_x_high),
    .out_mbr_y_high  (out_mbr_y_high),
    .out_level       (out_level),
    .out_first_child (out_first_child),
    .out_child_count (out_child_count),
    .out_rect_id     (out_rect_id),
    .out_node_count  (out_node_count)
  );

endmodule

[tb/rtree_bulk_load_builder_chk.sv]
// checker for the r-tree bulk load builder: watches both channels, predicts and compares
`timescale 1ns / 1ps
module rtree_bulk_load_builder_chk (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         in_cmd,
  input  logic signed [15:0] in_x_low,
  input  logic signed [15:0] in_y_low,
  input  logic signed [15:0] in_x_high,
  input  logic signed [15:0] in_y_high,
  input  logic [10:0]        in_addr,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_fanout,
  input  logic               out_valid,
  input  logic [2:0]         out_status,
  input  logic signed [15:0] out_mbr_x_low,
  input  logic signed [15:0] out_mbr_y_low,
  input  logic signed [15:0] out_mbr_x_high,
  input  logic signed [15:0] out_mbr_y_high,
  input  logic [3:0]         out_level,
  input  logic [10:0]        out_first_child,
  input  logic [3:0]         out_child_count,
  input  logic [9:0]         out_rect_id,
  input  logic [10:0]        out_node_count,
  output int                 fail_count,
  output int                 words_pending
);

  typedef struct {
    rtb_pkg::status_t   status;
    logic signed [15:0] xl, yl, xh, yh;
    logic [3:0]         level;
    logic [10:0]        first;
    logic [3:0]         count;
    logic [9:0]         rect_id;
    logic [10:0]        node_count;
  } node_reply_t;

  node_reply_t reply_q[$];

  rtb_pkg::box_t  rects[rtb_pkg::MaxRects];
  int             order[rtb_pkg::MaxRects];
  rtb_pkg::box_t  nbox[rtb_pkg::MaxNodes];
  rtb_pkg::link_t nlink[rtb_pkg::MaxNodes];
  int             nrects;
  int             nnodes;
  logic           built;
  logic [3:0]     fanout_reg;

  assign words_pending = reply_q.size();

  task automatic report(string what, int got, int want);
    $display("[%0t] %s got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  function automatic int center_of(rtb_pkg::box_t b);
    return (int'(b.xl) + int'(b.xh)) / 2;
  endfunction

  function automatic rtb_pkg::box_t widen(rtb_pkg::box_t a, rtb_pkg::box_t b);
    rtb_pkg::box_t r;
    r = a;
    if (b.xl < r.xl) r.xl = b.xl;
    if (b.yl < r.yl) r.yl = b.yl;
    if (b.xh > r.xh) r.xh = b.xh;
    if (b.yh > r.yh) r.yh = b.yh;
    return r;
  endfunction

  function automatic void fill_node(ref node_reply_t r, input int k);
    r.xl = nbox[k].xl;
    r.yl = nbox[k].yl;
    r.xh = nbox[k].xh;
    r.yh = nbox[k].yh;
    r.level = nlink[k].level;
    r.first = nlink[k].first;
    r.count = nlink[k].count;
  endfunction

  function automatic rtb_pkg::status_t pack_tree(ref node_reply_t r);
    int m, n, cnt, total, i, j, k, key, c, first, base, nxt, lvl, parents;
    n = nrects;
    built = 1'b0;
    nnodes = 0;
    if (n == 0) return rtb_pkg::ST_EMPTY;
    m = fanout_reg < 2 ? 2 :
        (fanout_reg > rtb_pkg::MaxFanout ? rtb_pkg::MaxFanout : fanout_reg);
    cnt = (n + m - 1) / m;
    total = cnt;
    while (cnt > 1) begin
      cnt = (cnt + m - 1) / m;
      total += cnt;
    end
    if (total > rtb_pkg::MaxNodes) return rtb_pkg::ST_FULL;
    for (i = 0; i < n; i++) order[i] = i;
    for (i = 1; i < n; i++) begin
      key = order[i];
      j = i;
      while (j > 0 && center_of(rects[order[j-1]]) > center_of(rects[key])) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = key;
    end
    cnt = (n + m - 1) / m;
    for (i = 0; i < cnt; i++) begin
      first = i * m;
      c = (n - first) < m ? n - first : m;
      nbox[i] = rects[order[first]];
      for (k = 1; k < c; k++) nbox[i] = widen(nbox[i], rects[order[first + k]]);
      nlink[i].level = '0;
      nlink[i].first = rtb_pkg::NIW'(first);
      nlink[i].count = rtb_pkg::FW'(c);
    end
    base = 0;
    nxt = cnt;
    lvl = 0;
    while (cnt > 1) begin
      parents = (cnt + m - 1) / m;
      lvl++;
      for (i = 0; i < parents; i++) begin
        first = base + i * m;
        c = (cnt - i * m) < m ? cnt - i * m : m;
        nbox[nxt] = nbox[first];
        for (k = 1; k < c; k++) nbox[nxt] = widen(nbox[nxt], nbox[first + k]);
        nlink[nxt].level = rtb_pkg::LVW'(lvl);
        nlink[nxt].first = rtb_pkg::NIW'(first);
        nlink[nxt].count = rtb_pkg::FW'(c);
        nxt++;
      end
      base = nxt - parents;
      cnt = parents;
    end
    nnodes = nxt;
    built = 1'b1;
    fill_node(r, nxt - 1);
    return rtb_pkg::ST_OK;
  endfunction

  function automatic node_reply_t predict_word();
    node_reply_t r;
    r = '{status: rtb_pkg::ST_OK, default: '0};
    case (rtb_pkg::cmd_t'(in_cmd))
      rtb_pkg::CMD_LOAD: begin
        if (nrects >= rtb_pkg::MaxRects) r.status = rtb_pkg::ST_FULL;
        else begin
          rects[nrects] = '{in_x_low, in_y_low, in_x_high, in_y_high};
          r.rect_id = 10'(nrects);
          nrects++;
          built = 1'b0;
          nnodes = 0;
        end
      end
      rtb_pkg::CMD_BUILD: r.status = pack_tree(r);
      rtb_pkg::CMD_RNODE: begin
        if (!built) r.status = rtb_pkg::ST_NOTBUILT;
        else if (in_addr >= nnodes) r.status = rtb_pkg::ST_RANGE;
        else fill_node(r, in_addr);
      end
      default: begin
        if (!built) r.status = rtb_pkg::ST_NOTBUILT;
        else if (in_addr >= nrects) r.status = rtb_pkg::ST_RANGE;
        else r.rect_id = 10'(order[in_addr]);
      end
    endcase
    r.node_count = built ? 11'(nnodes) : '0;
    return r;
  endfunction

  always @(posedge clk) begin
    node_reply_t w;
    if (!rst_n) begin
      nrects = 0;
      nnodes = 0;
      built = 1'b0;
      fanout_reg = 4'd4;
      reply_q.delete();
    end else begin
      if (cfg_we) fanout_reg = cfg_fanout;
      if (out_valid) begin
        if (reply_q.size() == 0) report("unexpected word status", out_status, 0);
        else begin
          w = reply_q.pop_front();
          if (out_status != w.status) report("status", out_status, w.status);
          if (out_mbr_x_low != w.xl) report("mbr_x_low", out_mbr_x_low, w.xl);
          if (out_mbr_y_low != w.yl) report("mbr_y_low", out_mbr_y_low, w.yl);
          if (out_mbr_x_high != w.xh) report("mbr_x_high", out_mbr_x_high, w.xh);
          if (out_mbr_y_high != w.yh) report("mbr_y_high", out_mbr_y_high, w.yh);
          if (out_level != w.level) report("level", out_level, w.level);
          if (out_first_child != w.first) report("first_child", out_first_child, w.first);
          if (out_child_count != w.count) report("child_count", out_child_count, w.count);
          if (out_rect_id != w.rect_id) report("rect_id", out_rect_id, w.rect_id);
          if (out_node_count != w.node_count)
            report("node_count", out_node_count, w.node_count);
        end
      end
      if (start && !busy) reply_q.push_back(predict_word());
    end
  end

  initial fail_count = 0;

endmodule

[tb/rtree_bulk_load_builder_tb.sv]
// testbench top for the r-tree bulk load builder: stimulus, clock, reset and verdict
`timescale 1ns / 1ps
module rtree_bulk_load_builder_tb;

  localparam int CycleLimit = 1_000_000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_cmd = '0;
  logic signed [15:0] in_x_low = '0, in_y_low = '0, in_x_high = '0, in_y_high = '0;
  logic [10:0]        in_addr = '0;
  logic               cfg_we = 1'b0;
  logic [3:0]         cfg_fanout = 4'd4;
  logic               out_valid;
  logic [2:0]         out_status;
  logic signed [15:0] out_mbr_x_low, out_mbr_y_low, out_mbr_x_high, out_mbr_y_high;
  logic [3:0]         out_level, out_child_count;
  logic [10:0]        out_first_child, out_node_count;
  logic [9:0]         out_rect_id;
  int                 fail_count, words_pending;
  int                 cycles = 0;
  int                 idle_pct = 0;
  int                 loads_done = 0;

  always #5 clk = ~clk;

  rtree_bulk_load_builder dut (.*);
  rtree_bulk_load_builder_chk chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // called at a falling edge with start low, returns at the falling edge after the take
  task automatic send_word(rtb_pkg::cmd_t c, int xl, int yl, int xh, int yh, int a);
    int gap;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 4);
      repeat (gap) @(negedge clk);
    end
    while (busy) @(negedge clk);
    start <= 1'b1;
    in_cmd <= c;
    in_x_low <= 16'(xl);
    in_y_low <= 16'(yl);
    in_x_high <= 16'(xh);
    in_y_high <= 16'(yh);
    in_addr <= 11'(a);
    @(negedge clk);
    start <= 1'b0;
    if (c == rtb_pkg::CMD_LOAD) loads_done++;
  endtask

  task automatic rand_word(rtb_pkg::cmd_t c, int a);
    send_word(c, $urandom_range(0, 65535), $urandom_range(0, 65535),
              $urandom_range(0, 65535), $urandom_range(0, 65535), a);
  endtask

  task automatic drain();
    @(negedge clk);
    while (words_pending != 0) @(negedge clk);
  endtask

  task automatic set_fanout(logic [3:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_fanout <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic int pick_addr();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 40) : $urandom_range(0, 2047);
  endfunction

  function automatic logic [3:0] pick_fanout();
    case ($urandom_range(0, 7))
      0: return 4'd0;
      1: return 4'd1;
      2: return 4'd2;
      3: return 4'd8;
      4: return 4'd15;
      5: return 4'd9;
      default: return 4'($urandom_range(0, 15));
    endcase
  endfunction

  initial begin
    int i, r, phase;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed
    send_word(rtb_pkg::CMD_RNODE, 0, 0, 0, 0, 0);
    send_word(rtb_pkg::CMD_RSORT, 0, 0, 0, 0, 0);
    send_word(rtb_pkg::CMD_BUILD, 0, 0, 0, 0, 0);
    send_word(rtb_pkg::CMD_LOAD, -32768, -32768, 32767, 32767, 0);
    send_word(rtb_pkg::CMD_LOAD, 32767, 32767, -32768, -32768, 2047);
    send_word(rtb_pkg::CMD_LOAD, -32768, 0, -32767, 5, 0);
    send_word(rtb_pkg::CMD_LOAD, -3, 0, 2, 0, 0);
    send_word(rtb_pkg::CMD_LOAD, 0, 0, 0, 0, 0);
    send_word(rtb_pkg::CMD_LOAD, 1, -7, -1, 9, 0);
    send_word(rtb_pkg::CMD_LOAD, 32767, 32767, 32767, 32767, 0);
    set_fanout(4'd2);
    send_word(rtb_pkg::CMD_BUILD, 0, 0, 0, 0, 0);
    for (i = 0; i < 5; i++) send_word(rtb_pkg::CMD_RNODE, 0, 0, 0, 0, i);
    send_word(rtb_pkg::CMD_RNODE, 0, 0, 0, 0, 2047);
    for (i = 0; i < 4; i++) send_word(rtb_pkg::CMD_RSORT, 0, 0, 0, 0, i * 2);
    send_word(rtb_pkg::CMD_RSORT, 0, 0, 0, 0, 7);
    send_word(rtb_pkg::CMD_RSORT, 0, 0, 0, 0, 1024);

    // random, in idling phases
    for (phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 1) ? 57 : (phase == 2) ? 13 : 0;
      set_fanout(pick_fanout());
      send_word(rtb_pkg::CMD_BUILD, 0, 0, 0, 0, 0);
      for (i = 0; i < 25; i++) begin
        r = $urandom_range(0, 99);
        if (r < 40) rand_word(rtb_pkg::CMD_LOAD, pick_addr());
        else if (r < 48) begin
          if ($urandom_range(0, 1) == 0) set_fanout(pick_fanout());
          rand_word(rtb_pkg::CMD_BUILD, pick_addr());
        end else if (r < 74) rand_word(rtb_pkg::CMD_RNODE, pick_addr());
        else rand_word(rtb_pkg::CMD_RSORT, pick_addr());
      end
    end

    // fill the store, then overflow it
    idle_pct = 0;
    while (loads_done < rtb_pkg::MaxRects + 4) rand_word(rtb_pkg::CMD_LOAD, pick_addr());
    rand_word(rtb_pkg::CMD_RNODE, 0);
    rand_word(rtb_pkg::CMD_RSORT, 2047);

    drain();
    repeat (20) @(negedge clk);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[rtree_bulk_load_builder.f]
rtl/rtb_pkg.sv
rtl/rtb_ctrl.sv
rtl/rtb_dp.sv
rtl/rtree_bulk_load_builder.sv
tb/rtree_bulk_load_builder_chk.sv
tb/rtree_bulk_load_builder_tb.sv
